// File: rtl/uve_pkg.sv
// shared types and constants of the utf-8 validating escaper
`default_nettype none

package uve_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_FLUSH
    } uve_state_t;

    typedef enum logic [2:0] {
        TOK_PLAIN,
        TOK_ESC2,
        TOK_HEX_X,
        TOK_UNI_U,
        TOK_UNI_4
    } uve_tok_t;

    typedef struct packed {
        logic load;
        logic latch;
        logic emit;
        logic flush;
        logic commit;
    } uve_cmd_t;

    typedef struct packed {
        logic at_end;
        logic tok_last;
        logic held_valid;
        logic out_free;
    } uve_stat_t;

    localparam logic [6:0] CH_BSLASH = 7'h5c;
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_LC_T   = 7'h74;
    localparam logic [6:0] CH_LC_N   = 7'h6e;
    localparam logic [6:0] CH_LC_R   = 7'h72;
    localparam logic [6:0] CH_LC_X   = 7'h78;
    localparam logic [6:0] CH_LC_U   = 7'h75;
    localparam logic [6:0] CH_UC_U   = 7'h55;
    localparam logic [6:0] CH_ZERO   = 7'h30;

    localparam logic [3:0] LEN_PLAIN = 4'd1;
    localparam logic [3:0] LEN_ESC2  = 4'd2;
    localparam logic [3:0] LEN_HEX_X = 4'd4;
    localparam logic [3:0] LEN_UNI_U = 4'd6;
    localparam logic [3:0] LEN_UNI_4 = 4'd10;

endpackage

`default_nettype wire

// File: rtl/uve_in_if.sv
// raw byte channel of the escaper
`default_nettype none

interface uve_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// File: rtl/uve_out_if.sv
// escaped text channel of the escaper
`default_nettype none

interface uve_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/uve_ctrl.sv
// sequencing state machine of the escaper
`default_nettype none

module uve_ctrl
    import uve_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  uve_stat_t  stat,
    output uve_cmd_t   cmd
);

    uve_state_t state_reg;
    uve_state_t state_next;
    logic       go;

    assign go = !stat.held_valid || stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.at_end)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.held_valid)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (go && stat.tok_last)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                cmd.latch  = !stat.at_end;
                cmd.commit = stat.at_end && !stat.held_valid;
            end
            ST_EMIT:
            begin
                cmd.emit = go;
            end
            ST_FLUSH:
            begin
                cmd.flush  = stat.out_free;
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/uve_datapath.sv
// byte queue, sequence decoder, character generator and output register
`default_nettype none

module uve_datapath
    import uve_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  uve_cmd_t   cmd,
    output uve_stat_t  stat,
    input  wire [7:0]  in_byte,
    input  wire        end_of_string,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [6:0] out_byte,
    output logic       last_of_run
);

    logic [7:0]  q_reg [4];
    logic [1:0]  pend_cnt_reg;
    logic [2:0]  n_reg;
    logic [2:0]  pos_reg;
    logic        final_reg;

    uve_tok_t    tok_kind_reg;
    logic [23:0] tok_val_reg;
    logic [3:0]  tok_len_reg;
    logic [3:0]  tok_idx_reg;

    logic [6:0]  held_reg;
    logic        held_valid_reg;

    logic        out_valid_reg;
    logic [6:0]  out_byte_reg;
    logic        out_last_reg;

    // decode at the current position
    logic [7:0]  c;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [2:0]  avail;
    logic [2:0]  need;
    logic        conts_ok;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic        hold_rest;
    uve_tok_t    d_kind;
    logic [23:0] d_val;
    logic [3:0]  d_len;
    logic [2:0]  d_adv;

    logic [3:0]  nib_sel;
    logic [3:0]  nib;
    logic [6:0]  ch;
    logic        out_free;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return CH_ZERO + {3'd0, d};
        end
        return 7'h57 + {3'd0, d};
    endfunction

    always_comb
    begin
        c     = q_reg[pos_reg[1:0]];
        b1    = q_reg[2'(pos_reg + 3'd1)];
        b2    = q_reg[2'(pos_reg + 3'd2)];
        b3    = q_reg[2'(pos_reg + 3'd3)];
        avail = n_reg - pos_reg;

        if ((c & 8'he0) == 8'hc0)
        begin
            need = 3'd2;
        end
        else if ((c & 8'hf0) == 8'he0)
        begin
            need = 3'd3;
        end
        else if ((c & 8'hf8) == 8'hf0)
        begin
            need = 3'd4;
        end
        else
        begin
            need = 3'd1;
        end

        conts_ok = (b1[7:6] == 2'b10)
                && ((need < 3'd3) || (b2[7:6] == 2'b10))
                && ((need < 3'd4) || (b3[7:6] == 2'b10));
        v2 = {c[4:0], b1[5:0]};
        v3 = {c[3:0], b1[5:0], b2[5:0]};
        v4 = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};

        hold_rest = 1'b0;
        d_kind    = TOK_HEX_X;
        d_val     = {16'd0, c};
        d_len     = LEN_HEX_X;
        d_adv     = 3'd1;

        if (!c[7])
        begin
            unique case (c)
                8'h09:
                begin
                    d_kind = TOK_ESC2;
                    d_val  = {17'd0, CH_LC_T};
                    d_len  = LEN_ESC2;
                end
                8'h0a:
                begin
                    d_kind = TOK_ESC2;
                    d_val  = {17'd0, CH_LC_N};
                    d_len  = LEN_ESC2;
                end
                8'h0d:
                begin
                    d_kind = TOK_ESC2;
                    d_val  = {17'd0, CH_LC_R};
                    d_len  = LEN_ESC2;
                end
                8'h22:
                begin
                    d_kind = TOK_ESC2;
                    d_val  = {17'd0, CH_QUOTE};
                    d_len  = LEN_ESC2;
                end
                8'h5c:
                begin
                    d_kind = TOK_ESC2;
                    d_val  = {17'd0, CH_BSLASH};
                    d_len  = LEN_ESC2;
                end
                default:
                begin
                    if (c >= 8'h20 && c != 8'h7f)
                    begin
                        d_kind = TOK_PLAIN;
                        d_len  = LEN_PLAIN;
                    end
                end
            endcase
        end
        else if (need == 3'd1)
        begin
            d_kind = TOK_HEX_X;
        end
        else if (avail < need)
        begin
            hold_rest = !final_reg;
        end
        else if (conts_ok)
        begin
            if (need == 3'd2 && v2 >= 11'h080)
            begin
                d_kind = TOK_UNI_U;
                d_val  = {13'd0, v2};
                d_len  = LEN_UNI_U;
                d_adv  = 3'd2;
            end
            else if (need == 3'd3 && v3 >= 16'h0800 && !(v3 >= 16'hd800 && v3 < 16'he000))
            begin
                d_kind = TOK_UNI_U;
                d_val  = {8'd0, v3};
                d_len  = LEN_UNI_U;
                d_adv  = 3'd3;
            end
            else if (need == 3'd4 && v4 >= 21'h010000 && v4 < 21'h110000)
            begin
                d_kind = TOK_UNI_4;
                d_val  = {3'd0, v4};
                d_len  = LEN_UNI_4;
                d_adv  = 3'd4;
            end
        end
    end

    // character at the current index of the latched token
    always_comb
    begin
        nib_sel = tok_len_reg - 4'd1 - tok_idx_reg;
        case (nib_sel[2:0])
            3'd0:    nib = tok_val_reg[3:0];
            3'd1:    nib = tok_val_reg[7:4];
            3'd2:    nib = tok_val_reg[11:8];
            3'd3:    nib = tok_val_reg[15:12];
            3'd4:    nib = tok_val_reg[19:16];
            default: nib = tok_val_reg[23:20];
        endcase

        ch = hex_char(nib);
        unique case (tok_kind_reg)
            TOK_PLAIN:
            begin
                ch = tok_val_reg[6:0];
            end
            TOK_ESC2:
            begin
                ch = (tok_idx_reg == 4'd0) ? CH_BSLASH : tok_val_reg[6:0];
            end
            TOK_HEX_X:
            begin
                if (tok_idx_reg == 4'd0)
                begin
                    ch = CH_BSLASH;
                end
                else if (tok_idx_reg == 4'd1)
                begin
                    ch = CH_LC_X;
                end
            end
            TOK_UNI_U:
            begin
                if (tok_idx_reg == 4'd0)
                begin
                    ch = CH_BSLASH;
                end
                else if (tok_idx_reg == 4'd1)
                begin
                    ch = CH_LC_U;
                end
            end
            TOK_UNI_4:
            begin
                if (tok_idx_reg == 4'd0)
                begin
                    ch = CH_BSLASH;
                end
                else if (tok_idx_reg == 4'd1)
                begin
                    ch = CH_UC_U;
                end
                else if (tok_idx_reg < 4'd4)
                begin
                    ch = CH_ZERO;
                end
            end
            default:
            begin
                ch = CH_BSLASH;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    assign stat.at_end     = (pos_reg == n_reg) || hold_rest;
    assign stat.tok_last   = (tok_idx_reg == tok_len_reg - 4'd1);
    assign stat.held_valid = held_valid_reg;
    assign stat.out_free   = out_free;

    // byte queue, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg[pend_cnt_reg] <= in_byte;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (3'(pos_reg + 3'(i)) < 3'd4)
                begin
                    q_reg[i] <= q_reg[2'(pos_reg + 3'(i))];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            n_reg        <= 3'd0;
            pos_reg      <= 3'd0;
            final_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg     <= {1'b0, pend_cnt_reg} + 3'd1;
                pos_reg   <= 3'd0;
                final_reg <= end_of_string;
            end
            else if (cmd.latch)
            begin
                pos_reg <= pos_reg + d_adv;
            end
            if (cmd.commit)
            begin
                pend_cnt_reg <= 2'(n_reg - pos_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_kind_reg <= TOK_PLAIN;
            tok_len_reg  <= 4'd0;
            tok_idx_reg  <= 4'd0;
        end
        else if (cmd.latch)
        begin
            tok_kind_reg <= d_kind;
            tok_len_reg  <= d_len;
            tok_idx_reg  <= 4'd0;
        end
        else if (cmd.emit)
        begin
            tok_idx_reg <= tok_idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            tok_val_reg <= d_val;
        end
    end

    // one character held back until it is known whether it ends the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            held_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            held_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            held_reg <= ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.emit && held_valid_reg) || cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.emit && held_valid_reg) || cmd.flush)
        begin
            out_byte_reg <= held_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= n_reg)
        else $error("queue position beyond byte count");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> tok_idx_reg < tok_len_reg)
        else $error("character index beyond token length");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.flush |-> held_valid_reg)
        else $error("flush without a held character");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |-> !held_valid_reg)
        else $error("held character left over from previous beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && held_valid_reg) || cmd.flush |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// File: rtl/utf8_validating_escaper_unit.sv
// top level of the utf-8 validating escaper
`default_nettype none

// Takes a byte string one beat per byte on raw, with end_of_string on the final
// byte, and emits escaped ascii text one character per beat on text; last_of_run
// marks the final character caused by an input beat. Bytes of an unfinished
// multi-byte sequence are held until it completes or the string ends. One byte
// is handled at a time: a beat is taken only when the previous one is fully
// resolved. For each input beat the byte is loaded, then each token it resolves (a
// character, an escape or a whole scalar) is decoded and its output characters
// (1, 2, 4, 6 or 10) are generated one per cycle while the text side does not
// stall, and the last held character is flushed; a byte that is only held gives
// no output. The sequencer runs decode and character generation through one shared
// decoder and one character-per-cycle generator.
module utf8_validating_escaper_unit
    import uve_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    uve_in_if.sink    raw,
    uve_out_if.source text
);

    uve_cmd_t  cmd;
    uve_stat_t stat;

    uve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (raw.valid),
        .in_ready (raw.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uve_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_byte       (raw.in_byte),
        .end_of_string (raw.end_of_string),
        .out_valid     (text.valid),
        .out_ready     (text.ready),
        .out_byte      (text.out_byte),
        .last_of_run   (text.last_of_run)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench of the utf-8 validating escaper with its own escaping predictor
module tb;
    import uve_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } raw_beat_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    localparam logic [7:0] B_TAB    = 8'h09;
    localparam logic [7:0] B_LF     = 8'h0a;
    localparam logic [7:0] B_CR     = 8'h0d;
    localparam logic [7:0] B_SPACE  = 8'h20;
    localparam logic [7:0] B_QUOTE  = 8'h22;
    localparam logic [7:0] B_BSLASH = 8'h5c;
    localparam logic [7:0] B_DEL    = 8'h7f;
    localparam logic [6:0] CH_LC_A  = 7'h61;
    localparam int RANDOM_BEATS = 440;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;

    uve_in_if  raw_ch ();
    uve_out_if text_ch ();

    utf8_validating_escaper_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .text  (text_ch)
    );

    raw_beat_t  pending_beats [$];
    text_char_t expected_text [$];
    text_char_t step_text [$];
    logic [7:0] held_bytes [3];
    int         held_count;
    int         beats_taken;
    int         total_beats;
    int         failures;
    int         send_idle;
    int         recv_idle;
    int         hold_left;
    bit         hold_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function void put_char(input logic [6:0] c);
        step_text.push_back('{ch: c, last: 1'b0});
    endfunction

    function void put_hex(input logic [6:0] kind, input logic [31:0] v, input int digits);
        int i;
        logic [3:0] d;
        put_char(CH_BSLASH);
        put_char(kind);
        for (i = digits; i > 0; i--)
        begin
            d = 4'(v >> (4 * (i - 1)));
            put_char(d < 4'd10 ? CH_ZERO + 7'(d) : CH_LC_A + 7'(d) - 7'd10);
        end
    endfunction

    function void escape_beat(input logic [7:0] data, input logic eos);
        logic [7:0] seq [4];
        logic [7:0] c;
        logic [31:0] cp;
        int n, pos, need, avail, i;
        bit ok;
        step_text.delete();
        n = held_count;
        for (i = 0; i < n; i++)
            seq[i] = held_bytes[i];
        seq[n] = data;
        n++;
        pos = 0;
        while (pos < n)
        begin
            c = seq[pos];
            avail = n - pos;
            if (c < 8'h80)
            begin
                case (c)
                    B_TAB:
                    begin
                        put_char(CH_BSLASH);
                        put_char(CH_LC_T);
                    end
                    B_LF:
                    begin
                        put_char(CH_BSLASH);
                        put_char(CH_LC_N);
                    end
                    B_CR:
                    begin
                        put_char(CH_BSLASH);
                        put_char(CH_LC_R);
                    end
                    B_QUOTE:
                    begin
                        put_char(CH_BSLASH);
                        put_char(CH_QUOTE);
                    end
                    B_BSLASH:
                    begin
                        put_char(CH_BSLASH);
                        put_char(CH_BSLASH);
                    end
                    default:
                    begin
                        if (c < B_SPACE || c == B_DEL)
                            put_hex(CH_LC_X, 32'(c), 2);
                        else
                            put_char(c[6:0]);
                    end
                endcase
                pos++;
                continue;
            end
            if (c[7:5] == 3'b110)
                need = 2;
            else if (c[7:4] == 4'b1110)
                need = 3;
            else if (c[7:3] == 5'b11110)
                need = 4;
            else
                need = 1;
            if (need == 1)
            begin
                put_hex(CH_LC_X, 32'(c), 2);
                pos++;
                continue;
            end
            if (avail < need)
            begin
                if (!eos)
                    break;
                put_hex(CH_LC_X, 32'(c), 2);
                pos++;
                continue;
            end
            ok = 1'b1;
            for (i = 1; i < need; i++)
                if (seq[pos + i][7:6] != 2'b10)
                    ok = 1'b0;
            if (ok)
            begin
                if (need == 2)
                begin
                    cp = 32'({c[4:0], seq[pos + 1][5:0]});
                    ok = cp >= 32'h80;
                end
                else if (need == 3)
                begin
                    cp = 32'({c[3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]});
                    ok = cp >= 32'h800 && !(cp >= 32'hd800 && cp < 32'he000);
                end
                else
                begin
                    cp = 32'({c[2:0], seq[pos + 1][5:0], seq[pos + 2][5:0],
                              seq[pos + 3][5:0]});
                    ok = cp >= 32'h10000 && cp < 32'h110000;
                end
            end
            if (ok)
            begin
                if (need == 4)
                    put_hex(CH_UC_U, cp, 8);
                else
                    put_hex(CH_LC_U, cp, 4);
                pos += need;
                continue;
            end
            put_hex(CH_LC_X, 32'(c), 2);
            pos++;
        end
        held_count = n - pos;
        for (i = 0; i < held_count; i++)
            held_bytes[i] = seq[pos + i];
        if (step_text.size() > 0)
            step_text[$].last = 1'b1;
        for (i = 0; i < step_text.size(); i++)
            expected_text.push_back(step_text[i]);
    endfunction

    function void add_beat(input logic [7:0] data, input logic eos);
        pending_beats.push_back('{data: data, eos: eos});
    endfunction

    always_comb
    begin
        if (beats_taken < total_beats / 3)
        begin
            send_idle = 23;
            recv_idle = 52;
        end
        else if (beats_taken < 2 * total_beats / 3)
        begin
            send_idle = 52;
            recv_idle = 23;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        raw_beat_t nxt;
        if (!rst_n)
        begin
            raw_ch.valid <= 1'b0;
            raw_ch.in_byte <= 8'h00;
            raw_ch.end_of_string <= 1'b0;
        end
        else
        begin
            if (raw_ch.valid && raw_ch.ready)
            begin
                escape_beat(raw_ch.in_byte, raw_ch.end_of_string);
                beats_taken++;
            end
            if (!raw_ch.valid || raw_ch.ready)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = pending_beats.pop_front();
                    raw_ch.valid <= 1'b1;
                    raw_ch.in_byte <= nxt.data;
                    raw_ch.end_of_string <= nxt.eos;
                end
                else
                    raw_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && beats_taken >= total_beats * 5 / 6)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : check_text
        text_char_t want;
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character, expected none actual %h last %b",
                             $time, text_ch.out_byte, text_ch.last_of_run);
                    failures++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_ch.out_byte !== want.ch)
                    begin
                        $display("%0t: out_byte mismatch, expected %h actual %h",
                                 $time, want.ch, text_ch.out_byte);
                        failures++;
                    end
                    if (text_ch.last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run mismatch, expected %b actual %b",
                                 $time, want.last, text_ch.last_of_run);
                        failures++;
                    end
                end
            end
            text_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin : run_test
        logic [7:0] str_bytes [$];
        logic [7:0] b;
        logic [20:0] cp;
        int tokens, len, tok_start, r, k, i;
        clk = 1'b0;
        rst_n = 1'b0;
        raw_ch.valid = 1'b0;
        raw_ch.in_byte = 8'h00;
        raw_ch.end_of_string = 1'b0;
        text_ch.ready = 1'b0;
        held_count = 0;
        beats_taken = 0;
        failures = 0;

        // ascii classes
        add_beat(8'h41, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(B_DEL, 1'b0);
        add_beat(B_TAB, 1'b0);
        add_beat(B_QUOTE, 1'b0);
        add_beat(B_BSLASH, 1'b0);
        // valid 2, 3 and 4 byte scalars, top of range
        add_beat(8'hc3, 1'b0);
        add_beat(8'ha9, 1'b0);
        add_beat(8'he2, 1'b0);
        add_beat(8'h82, 1'b0);
        add_beat(8'hac, 1'b0);
        add_beat(8'hf4, 1'b0);
        add_beat(8'h8f, 1'b0);
        add_beat(8'hbf, 1'b0);
        add_beat(8'hbf, 1'b0);
        // overlong, surrogate, out of range
        add_beat(8'hc1, 1'b0);
        add_beat(8'hbf, 1'b0);
        add_beat(8'hed, 1'b0);
        add_beat(8'ha0, 1'b0);
        add_beat(8'h80, 1'b0);
        add_beat(8'hf4, 1'b0);
        add_beat(8'h90, 1'b0);
        add_beat(8'h80, 1'b0);
        add_beat(8'h80, 1'b0);
        // bad continuation in 4-byte form, stray 0xff byte, cut off at end
        add_beat(8'hf0, 1'b0);
        add_beat(8'h9f, 1'b0);
        add_beat(8'h41, 1'b0);
        add_beat(8'hff, 1'b0);
        add_beat(8'he2, 1'b0);
        add_beat(8'h82, 1'b1);

        total_beats = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < total_beats)
        begin
            str_bytes.delete();
            tokens = $urandom_range(1, 8);
            repeat (tokens)
            begin
                r = $urandom_range(99);
                if (r < 35)
                    str_bytes.push_back(8'($urandom_range(0, 127)));
                else if (r < 82)
                begin
                    len = $urandom_range(2, 4);
                    tok_start = str_bytes.size();
                    if (len == 2)
                    begin
                        cp = 21'($urandom_range(21'h80, 21'h7ff));
                        str_bytes.push_back({3'b110, cp[10:6]});
                    end
                    else if (len == 3)
                    begin
                        do
                            cp = 21'($urandom_range(21'h800, 21'hffff));
                        while (cp >= 21'hd800 && cp < 21'he000);
                        str_bytes.push_back({4'b1110, cp[15:12]});
                        str_bytes.push_back({2'b10, cp[11:6]});
                    end
                    else
                    begin
                        cp = 21'($urandom_range(21'h10000, 21'h10ffff));
                        str_bytes.push_back({5'b11110, cp[20:18]});
                        str_bytes.push_back({2'b10, cp[17:12]});
                        str_bytes.push_back({2'b10, cp[11:6]});
                    end
                    str_bytes.push_back({2'b10, cp[5:0]});
                    // broken scalars: cut short or with a bad continuation
                    if (r >= 70)
                    begin
                        if ($urandom_range(1) == 0)
                            repeat ($urandom_range(1, len - 1))
                                void'(str_bytes.pop_back());
                        else
                        begin
                            b = 8'($urandom_range(255));
                            if (b[7:6] == 2'b10)
                                b[6] = 1'b1;
                            str_bytes[tok_start + $urandom_range(1, len - 1)] = b;
                        end
                    end
                end
                else if (r < 90)
                begin
                    // well-shaped but overlong, surrogate or out of range
                    k = $urandom_range(3);
                    case (k)
                        0: str_bytes.push_back(8'(8'hc0 | $urandom_range(1)));
                        1:
                        begin
                            str_bytes.push_back(8'he0);
                            str_bytes.push_back(8'(8'h80 + $urandom_range(31)));
                        end
                        2:
                        begin
                            str_bytes.push_back(8'hed);
                            str_bytes.push_back(8'(8'ha0 + $urandom_range(31)));
                        end
                        default:
                        begin
                            str_bytes.push_back(8'hf4);
                            str_bytes.push_back(8'(8'h90 + $urandom_range(47)));
                            str_bytes.push_back(8'(8'h80 | $urandom_range(63)));
                        end
                    endcase
                    str_bytes.push_back(8'(8'h80 | $urandom_range(63)));
                end
                else
                    str_bytes.push_back(8'($urandom_range(255)));
            end
            for (i = 0; i < str_bytes.size(); i++)
                add_beat(str_bytes[i], i == str_bytes.size() - 1);
        end
        total_beats = pending_beats.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || raw_ch.valid || expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
